@@ rtl/tridiagonal_complex_multiply_accumulate_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef TRIDIAGONAL_COMPLEX_MULTIPLY_ACCUMULATE_ASSERT_SVH
`define TRIDIAGONAL_COMPLEX_MULTIPLY_ACCUMULATE_ASSERT_SVH

// Property checked at every rising edge while reset is released.
`define TCMA_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define TCMA_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tcma_pkg.sv @@
`default_nettype none

package tcma_pkg;

	localparam int ORDER_W   = 11;
	localparam int COUNT_W   = 16;
	localparam int MODE_W    = 2;
	localparam int ROW_W     = 10;
	localparam int FRAC_BITS = 12;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = 4;
	localparam int CREDIT_W   = FIFO_AW + 1;

	// Position of each component inside one stored coefficient row.
	localparam int F_SUP_IM  = 0;
	localparam int F_SUP_RE  = 1;
	localparam int F_DIAG_IM = 2;
	localparam int F_DIAG_RE = 3;
	localparam int F_SUB_IM  = 4;
	localparam int F_SUB_RE  = 5;
	localparam int N_FIELDS  = 6;

	localparam logic [MODE_W-1:0] TM_PLAIN = 2'd0;
	localparam logic [MODE_W-1:0] TM_TRANS = 2'd1;
	localparam logic [MODE_W-1:0] TM_CONJ  = 2'd2;
	localparam logic [MODE_W-1:0] TM_NONE  = 2'd3;

	localparam logic [MODE_W-1:0] AM_ZERO  = 2'd0;
	localparam logic [MODE_W-1:0] AM_PLUS  = 2'd1;
	localparam logic [MODE_W-1:0] AM_MINUS = 2'd2;

	localparam logic [MODE_W-1:0] BM_ZERO  = 2'd0;
	localparam logic [MODE_W-1:0] BM_ONE   = 2'd1;
	localparam logic [MODE_W-1:0] BM_MINUS = 2'd2;

	localparam logic [0:0] CMD_LOAD = 1'b0;
	localparam logic [0:0] CMD_DATA = 1'b1;

	typedef enum logic [2:0] {
		REG_ORDER  = 3'd0,
		REG_COUNT  = 3'd1,
		REG_TRANS  = 3'd2,
		REG_ALPHA  = 3'd3,
		REG_BETA   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic             valid;
		logic             emit_a;
		logic             emit_b;
		logic             eom;
		logic [ROW_W-1:0] row;
	} ctrl_t;

	typedef struct packed {
		logic item;
		logic push_a;
		logic push_b;
	} push_t;

endpackage

`default_nettype wire

@@ rtl/tcma_coef_store.sv @@
`default_nettype none

module tcma_coef_store #(
	parameter int DEPTH = 1024,
	parameter int DW    = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/tcma_datapath.sv @@
`default_nettype none

module tcma_datapath #(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcma_pkg::ctrl_t     ctrl_s1,
	input  logic [2*W-1:0]      xbp_s1,
	input  logic [2*W-1:0]      xp_s1,
	input  logic [2*W-1:0]      x_s1,
	input  logic [2*W-1:0]      bprev_s1,
	input  logic [2*W-1:0]      b_s1,
	input  logic [6*W-1:0]      c1,
	input  logic [6*W-1:0]      c2,
	input  logic [6*W-1:0]      crd,
	input  logic [1:0]          tmode,
	input  logic [1:0]          amode,
	input  logic [1:0]          bmode,
	output tcma_pkg::push_t     push,
	output logic [2*W+12:0]     res_a,
	output logic [2*W+12:0]     res_b
);

	import tcma_pkg::*;

	localparam int NT = 5;
	localparam int PW = 2 * W + 1;
	localparam int TW = PW + 1;
	localparam int BW = W + FRAC_BITS + 1;
	localparam int AW = 2 * W + 6;
	localparam int QW = AW - FRAC_BITS;
	localparam logic signed [QW-1:0] QMAX = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [QW-1:0] QMIN = {{(QW-W+1){1'b1}}, {(W-1){1'b0}}};

	function automatic logic signed [W-1:0] fld(input logic [6*W-1:0] c, input int f);
		return c[f*W +: W];
	endfunction

	function automatic logic signed [BW-1:0] bscale(input logic signed [W-1:0] v,
		input logic [1:0] m);
		logic signed [BW-1:0] s;
		s = BW'(v) <<< FRAC_BITS;
		unique case (m)
			BM_ZERO:  s = '0;
			BM_MINUS: s = -s;
			default:  s = s;
		endcase
		return s;
	endfunction

	function automatic logic [W:0] finish(input logic signed [AW-1:0] ps,
		input logic signed [BW-1:0] bs, input logic [1:0] am, input logic use_p);
		logic signed [AW-1:0] tot;
		logic signed [QW-1:0] q;
		tot = AW'(bs);
		if (use_p) begin
			unique case (am)
				AM_PLUS:  tot = tot + ps;
				AM_MINUS: tot = tot - ps;
				default:  tot = tot;
			endcase
		end
		q = QW'(tot >>> FRAC_BITS);
		if (q > QMAX) begin
			return {1'b1, QMAX[W-1:0]};
		end else if (q < QMIN) begin
			return {1'b1, QMIN[W-1:0]};
		end
		return {1'b0, q[W-1:0]};
	endfunction

	logic                 tm_plain;
	logic                 conj;
	logic signed [W-1:0]  cr [NT];
	logic signed [W-1:0]  ci [NT];
	logic signed [W:0]    cic [NT];
	logic signed [W-1:0]  xr [NT];
	logic signed [W-1:0]  xi [NT];

	logic signed [PW-1:0] prr_s2 [NT];
	logic signed [PW-1:0] pii_s2 [NT];
	logic signed [PW-1:0] pri_s2 [NT];
	logic signed [PW-1:0] pir_s2 [NT];
	logic [2*W-1:0]       bprev_s2;
	logic [2*W-1:0]       b_s2;
	ctrl_t                ctrl_s2;

	logic signed [TW-1:0] tre_s3 [NT];
	logic signed [TW-1:0] tim_s3 [NT];
	logic signed [BW-1:0] ba_re_s3;
	logic signed [BW-1:0] ba_im_s3;
	logic signed [BW-1:0] bb_re_s3;
	logic signed [BW-1:0] bb_im_s3;
	ctrl_t                ctrl_s3;

	logic                 use_p;
	logic signed [AW-1:0] ps_a_re;
	logic signed [AW-1:0] ps_a_im;
	logic signed [AW-1:0] ps_b_re;
	logic signed [AW-1:0] ps_b_im;
	logic [W:0]           fa_re;
	logic [W:0]           fa_im;
	logic [W:0]           fb_re;
	logic [W:0]           fb_im;

	// Terms 0 to 2 build the earlier row, terms 3 and 4 the closing row of a column.
	always_comb begin
		tm_plain = (tmode == TM_PLAIN);
		conj     = (tmode == TM_CONJ);

		cr[0] = fld(c1, F_DIAG_RE);
		ci[0] = fld(c1, F_DIAG_IM);
		xr[0] = xp_s1[2*W-1:W];
		xi[0] = xp_s1[W-1:0];

		cr[1] = tm_plain ? fld(c2, F_SUB_RE) : fld(c2, F_SUP_RE);
		ci[1] = tm_plain ? fld(c2, F_SUB_IM) : fld(c2, F_SUP_IM);
		xr[1] = xbp_s1[2*W-1:W];
		xi[1] = xbp_s1[W-1:0];

		cr[2] = tm_plain ? fld(c1, F_SUP_RE) : fld(c1, F_SUB_RE);
		ci[2] = tm_plain ? fld(c1, F_SUP_IM) : fld(c1, F_SUB_IM);
		xr[2] = x_s1[2*W-1:W];
		xi[2] = x_s1[W-1:0];

		cr[3] = fld(crd, F_DIAG_RE);
		ci[3] = fld(crd, F_DIAG_IM);
		xr[3] = x_s1[2*W-1:W];
		xi[3] = x_s1[W-1:0];

		cr[4] = tm_plain ? fld(c1, F_SUB_RE) : fld(c1, F_SUP_RE);
		ci[4] = tm_plain ? fld(c1, F_SUB_IM) : fld(c1, F_SUP_IM);
		xr[4] = xp_s1[2*W-1:W];
		xi[4] = xp_s1[W-1:0];

		for (int i = 0; i < NT; i++) begin
			cic[i] = conj ? -((W+1)'(ci[i])) : (W+1)'(ci[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NT; i++) begin
			prr_s2[i] <= PW'(cr[i]) * PW'(xr[i]);
			pii_s2[i] <= PW'(cic[i]) * PW'(xi[i]);
			pri_s2[i] <= PW'(cr[i]) * PW'(xi[i]);
			pir_s2[i] <= PW'(cic[i]) * PW'(xr[i]);
		end
		bprev_s2 <= bprev_s1;
		b_s2     <= b_s1;

		for (int i = 0; i < NT; i++) begin
			tre_s3[i] <= TW'(prr_s2[i]) - TW'(pii_s2[i]);
			tim_s3[i] <= TW'(pri_s2[i]) + TW'(pir_s2[i]);
		end
		ba_re_s3 <= bscale(bprev_s2[2*W-1:W], bmode);
		ba_im_s3 <= bscale(bprev_s2[W-1:0], bmode);
		bb_re_s3 <= bscale(b_s2[2*W-1:W], bmode);
		bb_im_s3 <= bscale(b_s2[W-1:0], bmode);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_comb begin
		use_p   = ((amode == AM_PLUS) || (amode == AM_MINUS)) && (tmode != TM_NONE);
		ps_a_re = AW'(tre_s3[0]) + AW'(tre_s3[1]) + AW'(tre_s3[2]);
		ps_a_im = AW'(tim_s3[0]) + AW'(tim_s3[1]) + AW'(tim_s3[2]);
		ps_b_re = AW'(tre_s3[3]) + AW'(tre_s3[4]);
		ps_b_im = AW'(tim_s3[3]) + AW'(tim_s3[4]);
		fa_re   = finish(ps_a_re, ba_re_s3, amode, use_p);
		fa_im   = finish(ps_a_im, ba_im_s3, amode, use_p);
		fb_re   = finish(ps_b_re, bb_re_s3, amode, use_p);
		fb_im   = finish(ps_b_im, bb_im_s3, amode, use_p);
	end

	assign res_a = {fa_re[W-1:0], fa_im[W-1:0], ROW_W'(ctrl_s3.row - 1'b1),
		1'b0, 1'b0, fa_re[W] | fa_im[W]};
	assign res_b = {fb_re[W-1:0], fb_im[W-1:0], ctrl_s3.row,
		1'b1, ctrl_s3.eom, fb_re[W] | fb_im[W]};

	assign push.item   = ctrl_s3.valid;
	assign push.push_a = ctrl_s3.valid & ctrl_s3.emit_a;
	assign push.push_b = ctrl_s3.valid & ctrl_s3.emit_b;

endmodule

`default_nettype wire

@@ rtl/tcma_result_fifo.sv @@
`default_nettype none

module tcma_result_fifo #(
	parameter int DW = 45
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_a,
	input  logic          push_b,
	input  logic [DW-1:0] data_a,
	input  logic [DW-1:0] data_b,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] rdata
);

	import tcma_pkg::*;

	logic [DW-1:0]      mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] wp_nx;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0]   cnt_q;
	logic [1:0]         npush;
	logic               pop;

	assign wp_nx     = wp_q + 1'b1;
	assign npush     = {1'b0, push_a} + {1'b0, push_b};
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & out_ready;
	assign rdata     = mem_q[rp_q];

	// The earlier row of a pair always takes the first free slot.
	always_ff @(posedge clk) begin
		if (push_a | push_b) begin
			mem_q[wp_q] <= push_a ? data_a : data_b;
		end
		if (push_a & push_b) begin
			mem_q[wp_nx] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_AW'(npush);
			rp_q  <= rp_q + FIFO_AW'(pop);
			cnt_q <= cnt_q + (FIFO_AW+1)'(npush) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

@@ rtl/tridiagonal_complex_multiply_accumulate.sv @@
// Channel   Handshake                        Moves
// in        in_valid / in_ready              one coefficient row or one X and B word
// out       out_valid / out_ready            one updated B word with row and flags
// cfg       psel, penable, pwrite, pready    one register write or read
//
// A word is accepted in every cycle while in_ready is high.
// A result passes the registers s1, s2 and s3 before it is written to the queue.
// in_ready falls when the 16-entry result queue, less two slots held for each
// word in the three pipeline stages, has fewer than two slots free.
// Reset clears counters, data window, pipeline and queue; the coefficient
// memory holds nothing defined until rows are loaded.
`default_nettype none

module tridiagonal_complex_multiply_accumulate #(
	parameter int MAX_ORDER       = 1024,
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tcma_pkg::PADDR_W-1:0]         paddr,
	input  logic [tcma_pkg::PDATA_W-1:0]         pwdata,
	output logic [tcma_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 cmd,
	input  logic [tcma_pkg::ROW_W-1:0]           load_row,
	input  logic signed [COMPONENT_WIDTH-1:0]    sub_re,
	input  logic signed [COMPONENT_WIDTH-1:0]    sub_im,
	input  logic signed [COMPONENT_WIDTH-1:0]    diag_re,
	input  logic signed [COMPONENT_WIDTH-1:0]    diag_im,
	input  logic signed [COMPONENT_WIDTH-1:0]    sup_re,
	input  logic signed [COMPONENT_WIDTH-1:0]    sup_im,
	input  logic signed [COMPONENT_WIDTH-1:0]    x_re,
	input  logic signed [COMPONENT_WIDTH-1:0]    x_im,
	input  logic signed [COMPONENT_WIDTH-1:0]    b_re,
	input  logic signed [COMPONENT_WIDTH-1:0]    b_im,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [COMPONENT_WIDTH-1:0]    out_re,
	output logic signed [COMPONENT_WIDTH-1:0]    out_im,
	output logic [tcma_pkg::ROW_W-1:0]           out_row,
	output logic                                 end_of_column,
	output logic                                 end_of_matrix,
	output logic                                 saturated
);

	import tcma_pkg::*;

	localparam int W   = COMPONENT_WIDTH;
	localparam int AW  = $clog2(MAX_ORDER);
	localparam int CW  = N_FIELDS * W;
	localparam int RW  = 2 * W + ROW_W + 3;
	localparam logic [ORDER_W-1:0] N_LIMIT =
		(MAX_ORDER > (1 << ORDER_W) - 1) ? ORDER_W'((1 << ORDER_W) - 1) : ORDER_W'(MAX_ORDER);

	logic [ORDER_W-1:0]  order_q;
	logic [COUNT_W-1:0]  count_q;
	logic [MODE_W-1:0]   tmode_q;
	logic [MODE_W-1:0]   amode_q;
	logic [MODE_W-1:0]   bmode_q;
	logic                cfg_wr;

	logic [ORDER_W-1:0]  row_q;
	logic [COUNT_W-1:0]  col_q;
	logic [2*W-1:0]      xp_q;
	logic [2*W-1:0]      xbp_q;
	logic [2*W-1:0]      bp_q;

	logic [ORDER_W-1:0]  n_eff;
	logic [COUNT_W-1:0]  cols_eff;
	logic [ORDER_W-1:0]  k;
	logic [ORDER_W-1:0]  k_next;
	logic [COUNT_W-1:0]  col;
	logic                last_col;
	logic                wrap;
	logic [2*W-1:0]      x_in;
	logic [2*W-1:0]      b_in;
	logic [2*W-1:0]      xp_eff;

	logic                acc;
	logic                data_acc;
	logic                load_ok;
	logic [AW-1:0]       load_addr;
	logic [CW-1:0]       load_word;
	logic [CW-1:0]       rdata;

	ctrl_t               ctrl_s1;
	logic [ORDER_W-1:0]  krow_s1;
	logic [2*W-1:0]      xbp_s1;
	logic [2*W-1:0]      xp_s1;
	logic [2*W-1:0]      x_s1;
	logic [2*W-1:0]      bprev_s1;
	logic [2*W-1:0]      b_s1;

	logic [CW-1:0]       c1_q;
	logic [CW-1:0]       c2_q;
	logic [AW-1:0]       c1_tag_q;
	logic [AW-1:0]       c2_tag_q;
	logic [CW-1:0]       c1_sh;
	logic [CW-1:0]       c2_sh;
	logic [AW-1:0]       c1_tag_sh;
	logic [AW-1:0]       c2_tag_sh;

	push_t               push;
	logic [RW-1:0]       res_a;
	logic [RW-1:0]       res_b;
	logic [RW-1:0]       res_head;
	logic [CREDIT_W-1:0] free_q;
	logic [CREDIT_W-1:0] release_n;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_W'(1);
			count_q <= COUNT_W'(1);
			tmode_q <= TM_PLAIN;
			amode_q <= AM_PLUS;
			bmode_q <= BM_ONE;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_ORDER: order_q <= pwdata[ORDER_W-1:0];
				REG_COUNT: count_q <= pwdata[COUNT_W-1:0];
				REG_TRANS: tmode_q <= pwdata[MODE_W-1:0];
				REG_ALPHA: amode_q <= pwdata[MODE_W-1:0];
				REG_BETA:  bmode_q <= pwdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_ORDER: prdata = PDATA_W'(order_q);
			REG_COUNT: prdata = PDATA_W'(count_q);
			REG_TRANS: prdata = PDATA_W'(tmode_q);
			REG_ALPHA: prdata = PDATA_W'(amode_q);
			REG_BETA:  prdata = PDATA_W'(bmode_q);
			default:   prdata = '0;
		endcase
	end

	// Row and column position of the incoming word.
	always_comb begin
		if (order_q == '0) begin
			n_eff = ORDER_W'(1);
		end else if (order_q > N_LIMIT) begin
			n_eff = N_LIMIT;
		end else begin
			n_eff = order_q;
		end
		cols_eff = (count_q == '0) ? COUNT_W'(1) : count_q;
		k        = (row_q >= n_eff) ? '0 : row_q;
		col      = (col_q >= cols_eff) ? '0 : col_q;
		last_col = (({1'b0, col} + 1'b1) == {1'b0, cols_eff});
		k_next   = k + 1'b1;
		wrap     = (k_next == n_eff);
		x_in     = {x_re, x_im};
		b_in     = {b_re, b_im};
		xp_eff   = (k == '0) ? '0 : xp_q;
	end

	assign acc       = in_valid & in_ready;
	assign data_acc  = acc & (cmd == CMD_DATA);
	assign load_ok   = acc & (cmd == CMD_LOAD) & (32'(load_row) < MAX_ORDER);
	assign load_addr = AW'(load_row);
	assign load_word = {sub_re, sub_im, diag_re, diag_im, sup_re, sup_im};
	assign in_ready  = (free_q >= CREDIT_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			xp_q  <= '0;
			xbp_q <= '0;
			bp_q  <= '0;
		end else if (data_acc) begin
			row_q <= wrap ? '0 : k_next;
			if (wrap) begin
				col_q <= last_col ? '0 : col + 1'b1;
			end else begin
				col_q <= col;
			end
			xbp_q <= xp_eff;
			xp_q  <= x_in;
			bp_q  <= b_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid  <= data_acc;
			ctrl_s1.emit_a <= (k != '0);
			ctrl_s1.emit_b <= wrap;
			ctrl_s1.eom    <= last_col;
			ctrl_s1.row    <= ROW_W'(k);
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			krow_s1  <= k;
			xbp_s1   <= (k >= ORDER_W'(2)) ? xbp_q : '0;
			xp_s1    <= xp_eff;
			x_s1     <= x_in;
			bprev_s1 <= bp_q;
			b_s1     <= b_in;
		end
	end

	tcma_coef_store #(
		.DEPTH (MAX_ORDER),
		.DW    (CW)
	) u_store (
		.clk   (clk),
		.we    (load_ok),
		.waddr (load_addr),
		.wdata (load_word),
		.re    (data_acc),
		.raddr (AW'(k)),
		.rdata (rdata)
	);

	// The two rows above the current one are held next to the memory. A load that
	// hits one of them updates the held copy in the same cycle.
	always_comb begin
		c1_sh     = ctrl_s1.valid ? rdata : c1_q;
		c1_tag_sh = ctrl_s1.valid ? AW'(krow_s1) : c1_tag_q;
		c2_sh     = ctrl_s1.valid ? c1_q : c2_q;
		c2_tag_sh = ctrl_s1.valid ? c1_tag_q : c2_tag_q;
	end

	always_ff @(posedge clk) begin
		c1_q <= (load_ok && (c1_tag_sh == load_addr)) ? load_word : c1_sh;
		c2_q <= (load_ok && (c2_tag_sh == load_addr)) ? load_word : c2_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_tag_q <= '0;
			c2_tag_q <= '0;
		end else begin
			c1_tag_q <= c1_tag_sh;
			c2_tag_q <= c2_tag_sh;
		end
	end

	tcma_datapath #(
		.W (W)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_s1  (ctrl_s1),
		.xbp_s1   (xbp_s1),
		.xp_s1    (xp_s1),
		.x_s1     (x_s1),
		.bprev_s1 (bprev_s1),
		.b_s1     (b_s1),
		.c1       (c1_q),
		.c2       (c2_q),
		.crd      (rdata),
		.tmode    (tmode_q),
		.amode    (amode_q),
		.bmode    (bmode_q),
		.push     (push),
		.res_a    (res_a),
		.res_b    (res_b)
	);

	tcma_result_fifo #(
		.DW (RW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (push.push_a),
		.push_b    (push.push_b),
		.data_a    (res_a),
		.data_b    (res_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rdata     (res_head)
	);

	assign {out_re, out_im, out_row, end_of_column, end_of_matrix, saturated} = res_head;

	// Every data word holds two queue slots until its results are known.
	assign release_n = push.item ?
		(CREDIT_W'(2) - CREDIT_W'(push.push_a) - CREDIT_W'(push.push_b)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= CREDIT_W'(FIFO_DEPTH);
		end else begin
			free_q <= free_q - (data_acc ? CREDIT_W'(2) : '0) + release_n
				+ CREDIT_W'(out_valid & out_ready);
		end
	end

endmodule

`default_nettype wire

@@ rtl/tcma_checker.sv @@
`default_nettype none

`include "tridiagonal_complex_multiply_accumulate_assert.svh"

module tcma_checker #(
	parameter int W = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic signed [W-1:0] out_re,
	input logic signed [W-1:0] out_im,
	input logic                end_of_column,
	input logic                end_of_matrix,
	input logic                saturated
);

	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	`TCMA_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im)), "result word dropped or changed while stalled")
	`TCMA_ASSERT(a_eom_eoc, clk, arst_n, (out_valid && end_of_matrix |-> end_of_column), "end of matrix without end of column")
	`TCMA_ASSERT(a_sat_clip, clk, arst_n, (out_valid && saturated |-> (out_re == SMAX || out_re == SMIN || out_im == SMAX || out_im == SMIN)), "saturated flag without a clipped component")
	`TCMA_ASSERT_ALWAYS(a_reset_idle, clk, (!arst_n |-> !out_valid), "result offered during reset")

endmodule

bind tridiagonal_complex_multiply_accumulate tcma_checker #(
	.W (COMPONENT_WIDTH)
) u_tcma_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_re        (out_re),
	.out_im        (out_im),
	.end_of_column (end_of_column),
	.end_of_matrix (end_of_matrix),
	.saturated     (saturated)
);

`default_nettype wire

@@ tb/tridiagonal_complex_multiply_accumulate_tb.sv @@
`timescale 1ns / 1ps

module tridiagonal_complex_multiply_accumulate_tb;
	import tcma_pkg::*;

	localparam int MAX_ORDER    = 1024;
	localparam int RANDOM_WORDS = 700;
	localparam int IDLE_CYCLES  = 12;

	localparam logic [MODE_W-1:0] AM_UNUSED = 2'd3;
	localparam logic [MODE_W-1:0] BM_UNUSED = 2'd3;

	typedef logic signed [15:0] comp_t;

	localparam comp_t COMP_MAX = 16'sh7fff;
	localparam comp_t COMP_MIN = 16'sh8000;

	typedef struct packed {
		comp_t re;
		comp_t im;
	} cplx_t;

	typedef struct packed {
		logic [0:0]       cmd;
		logic [ROW_W-1:0] row;
		cplx_t            sub;
		cplx_t            diag;
		cplx_t            sup;
		cplx_t            x;
		cplx_t            b;
	} word_t;

	typedef struct packed {
		cplx_t sub;
		cplx_t diag;
		cplx_t sup;
	} coef_row_t;

	typedef struct packed {
		comp_t            re;
		comp_t            im;
		logic [ROW_W-1:0] row;
		logic             eoc;
		logic             eom;
		logic             sat;
	} update_t;

	logic clk;
	logic arst_n = 1'b0;

	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             cmd      = CMD_LOAD;
	logic [ROW_W-1:0] load_row = '0;
	comp_t            sub_re   = '0;
	comp_t            sub_im   = '0;
	comp_t            diag_re  = '0;
	comp_t            diag_im  = '0;
	comp_t            sup_re   = '0;
	comp_t            sup_im   = '0;
	comp_t            x_re     = '0;
	comp_t            x_im     = '0;
	comp_t            b_re     = '0;
	comp_t            b_im     = '0;

	logic             out_valid;
	logic             out_ready = 1'b0;
	comp_t            out_re;
	comp_t            out_im;
	logic [ROW_W-1:0] out_row;
	logic             end_of_column;
	logic             end_of_matrix;
	logic             saturated;

	tridiagonal_complex_multiply_accumulate dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.load_row      (load_row),
		.sub_re        (sub_re),
		.sub_im        (sub_im),
		.diag_re       (diag_re),
		.diag_im       (diag_im),
		.sup_re        (sup_re),
		.sup_im        (sup_im),
		.x_re          (x_re),
		.x_im          (x_im),
		.b_re          (b_re),
		.b_im          (b_im),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_re        (out_re),
		.out_im        (out_im),
		.out_row       (out_row),
		.end_of_column (end_of_column),
		.end_of_matrix (end_of_matrix),
		.saturated     (saturated)
	);

	logic [ORDER_W-1:0] m_order = 11'd1;
	logic [COUNT_W-1:0] m_count = 16'd1;
	logic [MODE_W-1:0]  m_trans = TM_PLAIN;
	logic [MODE_W-1:0]  m_alpha = AM_PLUS;
	logic [MODE_W-1:0]  m_beta  = BM_ONE;

	coef_row_t coef_mirror [MAX_ORDER];
	bit        row_loaded [MAX_ORDER];
	cplx_t     x_prev  = '0;
	cplx_t     x_prev2 = '0;
	cplx_t     b_prev  = '0;
	int        row_cnt = 0;
	int        col_cnt = 0;

	word_t   word_fifo[$];
	update_t pending_updates[$];
	int      words_queued   = 0;
	int      words_accepted = 0;
	int      errors         = 0;
	bit      in_calm        = 1'b0;
	bit      out_calm       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tridiagonal_complex_multiply_accumulate_tb failed");
		$finish;
	end

	function automatic int order_in_use(input logic [ORDER_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_ORDER)
			return MAX_ORDER;
		return int'(v);
	endfunction

	function automatic void cmac(inout longint acc_re, inout longint acc_im, input cplx_t a,
			input bit cj, input cplx_t x, input int sign);
		longint ar, ai, xr, xi;
		ar = longint'($signed(a.re));
		ai = cj ? -longint'($signed(a.im)) : longint'($signed(a.im));
		xr = longint'($signed(x.re));
		xi = longint'($signed(x.im));
		acc_re += sign * (ar * xr - ai * xi);
		acc_im += sign * (ar * xi + ai * xr);
	endfunction

	function automatic comp_t clip(input longint acc, inout bit clipped);
		longint q;
		q = acc >>> FRAC_BITS;
		if (q > 32767) begin
			clipped = 1'b1;
			return COMP_MAX;
		end
		if (q < -32768) begin
			clipped = 1'b1;
			return COMP_MIN;
		end
		return q[15:0];
	endfunction

	function automatic void emit_update(input int row, input int n, input bit last_col,
			input cplx_t xm, input cplx_t xc, input cplx_t xn, input cplx_t bv);
		longint acc_re, acc_im;
		int sign;
		bit cj, clipped;
		coef_row_t c, p;
		update_t u;
		sign = (m_alpha == AM_PLUS) ? 1 : ((m_alpha == AM_MINUS) ? -1 : 0);
		acc_re = longint'($signed(bv.re)) * 4096;
		acc_im = longint'($signed(bv.im)) * 4096;
		if (m_beta == BM_ZERO) begin
			acc_re = 0;
			acc_im = 0;
		end else if (m_beta == BM_MINUS) begin
			acc_re = -acc_re;
			acc_im = -acc_im;
		end
		if (sign != 0 && m_trans != TM_NONE) begin
			cj = (m_trans == TM_CONJ);
			c = coef_mirror[row];
			cmac(acc_re, acc_im, c.diag, cj, xc, sign);
			if (row > 0) begin
				p = coef_mirror[row - 1];
				cmac(acc_re, acc_im, (m_trans == TM_PLAIN) ? p.sub : p.sup, cj, xm, sign);
			end
			if (row + 1 < n)
				cmac(acc_re, acc_im, (m_trans == TM_PLAIN) ? c.sup : c.sub, cj, xn, sign);
		end
		clipped = 1'b0;
		u.re = clip(acc_re, clipped);
		u.im = clip(acc_im, clipped);
		u.row = row[ROW_W-1:0];
		u.eoc = (row + 1 == n);
		u.eom = (row + 1 == n) && last_col;
		u.sat = clipped;
		pending_updates.push_back(u);
	endfunction

	function automatic void apply_word(input word_t w);
		int n, cols, k;
		bit last_col;
		cplx_t zero;
		zero = '0;
		if (w.cmd == CMD_LOAD) begin
			coef_mirror[w.row].sub = w.sub;
			coef_mirror[w.row].diag = w.diag;
			coef_mirror[w.row].sup = w.sup;
			return;
		end
		n = order_in_use(m_order);
		cols = (m_count == 0) ? 1 : int'(m_count);
		if (row_cnt >= n)
			row_cnt = 0;
		if (col_cnt >= cols)
			col_cnt = 0;
		last_col = (col_cnt + 1 == cols);
		k = row_cnt;
		if (k == 0)
			x_prev = zero;
		else
			emit_update(k - 1, n, last_col, (k >= 2) ? x_prev2 : zero, x_prev, w.x, b_prev);
		if (k + 1 == n)
			emit_update(k, n, last_col, x_prev, w.x, zero, w.b);
		x_prev2 = x_prev;
		x_prev = w.x;
		b_prev = w.b;
		row_cnt = k + 1;
		if (row_cnt >= n) begin
			row_cnt = 0;
			col_cnt = last_col ? 0 : col_cnt + 1;
		end
	endfunction

	function automatic logic [PDATA_W-1:0] register_value(input reg_idx_t idx);
		case (idx)
			REG_ORDER: return {{(PDATA_W-ORDER_W){1'b0}}, m_order};
			REG_COUNT: return {{(PDATA_W-COUNT_W){1'b0}}, m_count};
			REG_TRANS: return {{(PDATA_W-MODE_W){1'b0}}, m_trans};
			REG_ALPHA: return {{(PDATA_W-MODE_W){1'b0}}, m_alpha};
			default:   return {{(PDATA_W-MODE_W){1'b0}}, m_beta};
		endcase
	endfunction

	function automatic string show(input update_t u);
		return $sformatf("re=%0d im=%0d row=%0d eoc=%0b eom=%0b sat=%0b",
			$signed(u.re), $signed(u.im), u.row, u.eoc, u.eom, u.sat);
	endfunction

	function automatic comp_t rand_comp();
		int v;
		case ($urandom_range(0, 5))
			0: return COMP_MAX;
			1: return COMP_MIN;
			2, 3: begin
				v = $urandom_range(0, 8191) - 4096;
				return v[15:0];
			end
			default: begin
				v = $urandom;
				return v[15:0];
			end
		endcase
	endfunction

	function automatic word_t random_word(input logic [0:0] kind, input logic [ROW_W-1:0] row);
		word_t w;
		w.cmd = kind;
		w.row = row;
		w.sub.re = rand_comp();
		w.sub.im = rand_comp();
		w.diag.re = rand_comp();
		w.diag.im = rand_comp();
		w.sup.re = rand_comp();
		w.sup.im = rand_comp();
		w.x.re = rand_comp();
		w.x.im = rand_comp();
		w.b.re = rand_comp();
		w.b.im = rand_comp();
		return w;
	endfunction

	function automatic word_t uniform_word(input logic [0:0] kind, input logic [ROW_W-1:0] row,
			input comp_t v);
		word_t w;
		w.cmd = kind;
		w.row = row;
		w.sub = {v, v};
		w.diag = {v, v};
		w.sup = {v, v};
		w.x = {v, v};
		w.b = {v, v};
		return w;
	endfunction

	task automatic send_word(input word_t w);
		if (w.cmd == CMD_LOAD)
			row_loaded[w.row] = 1'b1;
		word_fifo.push_back(w);
		words_queued++;
	endtask

	task automatic send_data(input int count);
		repeat (count)
			send_word(random_word(CMD_DATA, $urandom_range(0, MAX_ORDER - 1)));
	endtask

	task automatic ensure_rows(input int n);
		for (int r = 0; r < n; r++)
			if (!row_loaded[r])
				send_word(random_word(CMD_LOAD, r[ROW_W-1:0]));
	endtask

	task automatic wait_idle();
		int spin;
		wait (words_accepted == words_queued);
		spin = 0;
		while (pending_updates.size() != 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		if (pending_updates.size() != 0) begin
			$display("%0t ns: %0d expected words never arrived, next %s", $time,
				pending_updates.size(), show(pending_updates[0]));
			errors++;
			pending_updates.delete();
		end
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		wait_idle();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_ORDER: m_order = value[ORDER_W-1:0];
			REG_COUNT: m_count = value[COUNT_W-1:0];
			REG_TRANS: m_trans = value[MODE_W-1:0];
			REG_ALPHA: m_alpha = value[MODE_W-1:0];
			default:   m_beta = value[MODE_W-1:0];
		endcase
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== register_value(idx)) begin
			$display("%0t ns: register %0d read back expected %0h, got %0h", $time, idx,
				register_value(idx), prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_modes(input logic [MODE_W-1:0] trans, input logic [MODE_W-1:0] alpha,
			input logic [MODE_W-1:0] beta);
		cfg_write(REG_TRANS, trans);
		cfg_write(REG_ALPHA, alpha);
		cfg_write(REG_BETA, beta);
	endtask

	task automatic test_saturation_extremes();
		cfg_write(REG_ORDER, 2);
		cfg_write(REG_COUNT, 1);
		set_modes(TM_PLAIN, AM_PLUS, BM_ONE);
		send_word(uniform_word(CMD_LOAD, 10'd0, COMP_MAX));
		send_word(uniform_word(CMD_LOAD, 10'd1, COMP_MIN));
		send_word(uniform_word(CMD_LOAD, 10'd1023, COMP_MAX));
		send_word(uniform_word(CMD_DATA, 10'd0, COMP_MAX));
		send_word(uniform_word(CMD_DATA, 10'd1023, COMP_MIN));
		set_modes(TM_PLAIN, AM_MINUS, BM_MINUS);
		send_word(uniform_word(CMD_DATA, 10'd0, COMP_MIN));
		send_word(uniform_word(CMD_DATA, 10'd0, COMP_MAX));
	endtask

	task automatic test_mode_sweep();
		cfg_write(REG_ORDER, 3);
		cfg_write(REG_COUNT, 2);
		ensure_rows(3);
		set_modes(TM_PLAIN, AM_PLUS, BM_ZERO);
		send_data(3);
		set_modes(TM_TRANS, AM_MINUS, BM_ONE);
		send_data(3);
		set_modes(TM_CONJ, AM_PLUS, BM_MINUS);
		send_data(3);
		set_modes(TM_NONE, AM_PLUS, BM_UNUSED);
		send_data(3);
		set_modes(TM_CONJ, AM_ZERO, BM_ONE);
		send_data(3);
		set_modes(TM_PLAIN, AM_UNUSED, BM_MINUS);
		send_data(3);
	endtask

	task automatic test_order_one();
		set_modes(TM_CONJ, AM_MINUS, BM_ONE);
		cfg_write(REG_ORDER, 0);
		send_data(2);
		cfg_write(REG_ORDER, 1);
		send_data(2);
	endtask

	task automatic test_counter_restart();
		set_modes(TM_PLAIN, AM_PLUS, BM_ONE);
		cfg_write(REG_ORDER, 6);
		cfg_write(REG_COUNT, 3);
		ensure_rows(6);
		send_data(4);
		cfg_write(REG_ORDER, 3);
		send_data(3);
		cfg_write(REG_ORDER, 2);
		send_data(4);
		cfg_write(REG_COUNT, 1);
		send_data(2);
		cfg_write(REG_COUNT, 0);
		send_data(4);
	endtask

	task automatic test_column_extremes();
		set_modes(TM_TRANS, AM_PLUS, BM_MINUS);
		cfg_write(REG_ORDER, 2);
		cfg_write(REG_COUNT, 65535);
		send_data(10);
	endtask

	task automatic test_order_extremes();
		set_modes(TM_TRANS, AM_MINUS, BM_ONE);
		cfg_write(REG_ORDER, 2047);
		cfg_write(REG_COUNT, 1);
		ensure_rows(MAX_ORDER);
		send_data(MAX_ORDER);
		set_modes(TM_CONJ, AM_PLUS, BM_ZERO);
		cfg_write(REG_ORDER, MAX_ORDER);
		cfg_write(REG_COUNT, 2);
		send_data(40);
	endtask

	task automatic test_random_phases();
		int sent, n, len, pick;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 1)) begin
				pick = $urandom_range(0, 19);
				if (pick < 14)
					cfg_write(REG_ORDER, $urandom_range(0, 6));
				else if (pick < 19)
					cfg_write(REG_ORDER, $urandom_range(7, 40));
				else
					cfg_write(REG_ORDER, $urandom_range(41, 150));
			end
			if ($urandom_range(0, 1)) begin
				if ($urandom_range(0, 4) != 0)
					cfg_write(REG_COUNT, $urandom_range(0, 4));
				else
					cfg_write(REG_COUNT, $urandom_range(5, 65535));
			end
			if ($urandom_range(0, 1))
				cfg_write(REG_TRANS, $urandom_range(0, 3));
			if ($urandom_range(0, 1))
				cfg_write(REG_ALPHA, $urandom_range(0, 3));
			if ($urandom_range(0, 1))
				cfg_write(REG_BETA, $urandom_range(0, 3));
			n = order_in_use(m_order);
			ensure_rows(n);
			len = n * $urandom_range(1, 3);
			if ($urandom_range(0, 4) == 0)
				len = $urandom_range(1, n);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_word(random_word(CMD_LOAD, $urandom_range(0, n - 1)));
				send_data(1);
			end
			sent += len;
		end
	endtask

	initial begin
		forever begin
			repeat ($urandom_range(20, 300)) @(posedge clk);
			in_calm = ($urandom_range(0, 2) == 0);
			out_calm = ($urandom_range(0, 2) == 0);
		end
	end

	initial begin
		word_t held;
		int gap_left;
		held = '0;
		gap_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (in_valid && in_ready) begin
				apply_word(held);
				words_accepted++;
				gap_left = in_calm ? 0 : $urandom_range(0, 12);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (word_fifo.size() != 0) begin
					held = word_fifo.pop_front();
					in_valid <= 1'b1;
					cmd <= held.cmd;
					load_row <= held.row;
					sub_re <= held.sub.re;
					sub_im <= held.sub.im;
					diag_re <= held.diag.re;
					diag_im <= held.diag.im;
					sup_re <= held.sup.re;
					sup_im <= held.sup.im;
					x_re <= held.x.re;
					x_im <= held.x.im;
					b_re <= held.b.re;
					b_im <= held.b.im;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	initial begin
		update_t got, want;
		int stall;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				got = {out_re, out_im, out_row, end_of_column, end_of_matrix, saturated};
				if (pending_updates.size() == 0) begin
					$display("%0t ns: unexpected word %s", $time, show(got));
					errors++;
				end else begin
					want = pending_updates.pop_front();
					if (got !== want) begin
						$display("%0t ns: mismatch, expected %s, got %s", $time, show(want),
							show(got));
						errors++;
					end
				end
				stall = out_calm ? 0 : $urandom_range(0, 12);
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_saturation_extremes();
		test_mode_sweep();
		test_order_one();
		test_counter_restart();
		test_column_extremes();
		test_order_extremes();
		test_random_phases();
		wait_idle();
		if (errors == 0) begin
			$display("tridiagonal_complex_multiply_accumulate_tb passed");
		end else begin
			$display("tridiagonal_complex_multiply_accumulate_tb failed");
		end
		$finish;
	end

endmodule
